[hw/rtl/ukvt_pkg.sv]
// ----------------------------------------------------------------------------
// ukvt_pkg: shared types and constants for the unordered key/value table
// Request and result formats, action and status codes, store sizing and
// the sequencer state type.
// ----------------------------------------------------------------------------
package ukvt_pkg;

    // Store sizing
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 5;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;

    // Action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    // Status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FULL    = 2'd1;
    localparam logic [1:0] STS_EMPTY   = 2'd2;
    localparam logic [1:0] STS_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VAL_W-1:0]   value_out;
        logic [ENTRY_W-1:0] entry_count;
    } rsp_t;

    // One stored pair
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Write port of the entry store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } store_wr_t;

    // Read port of the entry store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } store_rd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } state_t;

endpackage

[hw/rtl/unordered_key_value_table.sv]
// ----------------------------------------------------------------------------
// unordered_key_value_table: fixed-capacity unordered key/value table
// Insert appends, lookup returns the first match, remove moves the last
// entry into the matching slot.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid / req_stall / req) carries one item: action,
//   key and value word. Result channel (rsp_valid / rsp_stall / rsp) returns
//   one item per request: status, value found by lookup, entry count.
//   An item is taken on a clock edge with valid high and stall low.
// Sequence
//   Insert, an unused action or a request on an empty or full table passes
//   through the done step and then the result register. Lookup and remove
//   walk the single store read port one entry a cycle, each compare using
//   the registered read data; then remove reads the last entry and writes
//   it over the match. A hit ends the scan early.
//   req_stall is high while an item is being worked on, so a new item is
//   taken only once the last one has been handed to the result register.
// Reset and stall
//   rst_n clears the entry count and the result valid flag; the stores are
//   not cleared, since only positions below the count are ever read.
//   The result is held in an output register; a new request is taken while
//   it waits, and that request stops before delivery until the receiver
//   takes the earlier result.
// ----------------------------------------------------------------------------
module unordered_key_value_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ukvt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ukvt_pkg::rsp_t rsp
);
    import ukvt_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [1:0]         action_reg, action_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [1:0]         status_reg, status_next;
    logic [VAL_W-1:0]   found_reg, found_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    store_wr_t          wr;
    store_rd_t          rd;
    entry_t             rd_data;

    logic               accept;
    logic               match;
    logic               scan_more;
    logic [CNT_W-1:0]   last_idx;

    ukvt_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign match     = cmp_valid_reg && (rd_data.key == key_reg);
    assign scan_more = (scan_idx_reg < count_reg);
    assign last_idx  = count_reg - CNT_W'(1);

    // Sequencer: next state, store access and result staging
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        pos_next       = pos_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr             = '0;
        rd             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next    = req.action;
                    key_next       = req.key;
                    status_next    = STS_OK;
                    found_next     = '0;
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_DONE;
                    if (req.action == ACT_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            // Append at the current count
                            wr.en         = 1'b1;
                            wr.addr       = count_reg[IDX_W-1:0];
                            wr.data.key   = req.key;
                            wr.data.value = req.value_in;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    else if (req.action == ACT_REMOVE || req.action == ACT_LOOKUP)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STS_EMPTY;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Compare the entry read last cycle, issue the next read
                if (match)
                begin
                    cmp_valid_next = 1'b0;
                    pos_next       = cmp_idx_reg;
                    if (action_reg == ACT_LOOKUP)
                    begin
                        found_next = rd_data.value;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MOVE_RD;
                    end
                end
                else if (scan_more)
                begin
                    rd.en          = 1'b1;
                    rd.addr        = scan_idx_reg[IDX_W-1:0];
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    status_next    = STS_MISSING;
                    state_next     = ST_DONE;
                end
            end

            ST_MOVE_RD:
            begin
                // Fetch the last entry
                rd.en      = 1'b1;
                rd.addr    = last_idx[IDX_W-1:0];
                state_next = ST_MOVE_WR;
            end

            ST_MOVE_WR:
            begin
                // Drop the last entry into the vacated slot
                wr.en      = 1'b1;
                wr.addr    = pos_reg;
                wr.data    = rd_data;
                count_next = last_idx;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hand the item over once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.value_out   = found_reg;
                    rsp_next.entry_count = ENTRY_W'(count_reg);
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        pos_reg      <= pos_next;
        action_reg   <= action_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer idle after taking an item");

    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE_WR |-> count_reg != '0)
        else $error("remove move on an empty table");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

endmodule

[hw/rtl/ukvt_store.sv]
// ----------------------------------------------------------------------------
// ukvt_store: entry store of the key/value table
// One write port and one read port; read data is registered and appears
// the cycle after the read is issued.
// ----------------------------------------------------------------------------
module ukvt_store (
    input  logic                clk,
    input  ukvt_pkg::store_wr_t wr,
    input  ukvt_pkg::store_rd_t rd,
    output ukvt_pkg::entry_t    rd_data
);
    import ukvt_pkg::*;

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    // Write a pair
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read one entry, registered
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[dv/ukvt_table_checker.sv]
// ----------------------------------------------------------------------------
// ukvt_table_checker: result checker for the unordered key/value table
// Watches both channels of the table. Each accepted request item is applied
// to a private copy of the table, and the result it should give is queued.
// Each accepted result item is compared field by field with the oldest
// queued result. The number of failures and the number of results still
// owed go back to the testbench top.
// ----------------------------------------------------------------------------
module ukvt_table_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  ukvt_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  ukvt_pkg::rsp_t rsp,
    output int             fail_count,
    output int             owed_count
);
    import ukvt_pkg::*;

    // Private copy of the table contents
    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];
    int unsigned      fill;

    rsp_t owed_results [$];
    int   mismatches;

    assign fail_count = mismatches;

    // Apply one request to the table copy and return the result it gives
    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int   hit;
        res = '0;
        hit = -1;
        case (r.action)
            ACT_INSERT:
            begin
                if (fill >= CAPACITY)
                begin
                    res.status = STS_FULL;
                end
                else
                begin
                    key_mem[fill] = r.key;
                    val_mem[fill] = r.value_in;
                    fill++;
                end
            end
            ACT_REMOVE, ACT_LOOKUP:
            begin
                if (fill == 0)
                begin
                    res.status = STS_EMPTY;
                end
                else
                begin
                    // keys match on the raw bit pattern, lowest slot wins
                    for (int i = 0; i < int'(fill); i++)
                    begin
                        if (hit < 0 && key_mem[i] == r.key)
                            hit = i;
                    end
                    if (hit < 0)
                    begin
                        res.status = STS_MISSING;
                    end
                    else if (r.action == ACT_LOOKUP)
                    begin
                        res.value_out = val_mem[hit];
                    end
                    else
                    begin
                        // move the last entry into the hole
                        key_mem[hit] = key_mem[fill - 1];
                        val_mem[hit] = val_mem[fill - 1];
                        fill--;
                    end
                end
            end
            default:
            begin
                // unused action: no change, plain ok
            end
        endcase
        res.entry_count = ENTRY_W'(fill);
        return res;
    endfunction

    // Compare one delivered result with its expectation
    task automatic compare_result(rsp_t got, rsp_t want);
        if (got.status !== want.status || got.value_out !== want.value_out ||
            got.entry_count !== want.entry_count)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result differs: status %0d/%0d value %h/%h count %0d/%0d",
                         $realtime, got.status, want.status, got.value_out,
                         want.value_out, got.entry_count, want.entry_count);
        end
    endtask

    // Track both channels; retire results before queueing new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            owed_results.delete();
            owed_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with no request waiting", $realtime);
                end
                else
                begin
                    compare_result(rsp, owed_results.pop_front());
                end
            end
            if (req_valid && !req_stall)
                owed_results.push_back(apply_request(req));
            owed_count <= owed_results.size();
        end
    end

    initial
    begin
        mismatches = 0;
        fill       = 0;
        owed_count = 0;
    end

endmodule

[dv/unordered_key_value_table_tb.sv]
// ----------------------------------------------------------------------------
// unordered_key_value_table_tb: testbench top for the key/value table
// Drives a short directed sequence over the special cases, then phases of
// random requests biased to fill, drain or churn the table over a small key
// pool. Both sides pause at random; one long receiver hold-off backs the
// table up. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module unordered_key_value_table_tb;
    import ukvt_pkg::*;

    // Action code the block leaves unused
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int PHASES       = 31;
    localparam int PHASE_ITEMS  = 50;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int fail_count;
    int owed_count;

    int tx_gap_max;
    int rx_gap_max;
    bit hold_request;

    logic [KEY_W-1:0] key_pool [6];

    unordered_key_value_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    ukvt_table_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_req(logic [1:0] act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        req_t item;
        int   gap;
        item.action   = act;
        item.key      = k;
        item.value_in = v;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
    endtask

    // Receiver: random stall before each item, one long hold-off on request
    initial
    begin : receiver
        int  wait_cycles;
        bit  held;
        rsp_stall = 1'b0;
        held      = 1'b0;
        forever
        begin
            if (hold_request && !held)
            begin
                held        = 1'b1;
                wait_cycles = LONG_HOLD;
            end
            else
            begin
                wait_cycles = $urandom_range(0, rx_gap_max);
            end
            if (wait_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // Reset, directed cases, random phases, verdict
    initial
    begin : stimulus
        int          pick;
        int          bias;
        logic [1:0]  act;
        logic [KEY_W-1:0] k;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        tx_gap_max   = 13;
        rx_gap_max   = 13;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, unused action
        send_req(ACT_LOOKUP, 32'h0000_0001, $urandom);
        send_req(ACT_REMOVE, 32'h0000_0001, $urandom);
        send_req(ACT_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // extreme keys and values
        send_req(ACT_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_req(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        // duplicates: first one wins, removal moves the last entry down
        send_req(ACT_INSERT, 32'hFFFF_FFFF, 32'hAAAA_5555);
        send_req(ACT_INSERT, 32'hFFFF_FFFF, 32'h5555_AAAA);
        send_req(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_req(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_req(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        // absent key
        send_req(ACT_LOOKUP, 32'h0000_0000, 32'h0);
        send_req(ACT_REMOVE, 32'h0000_0000, 32'h0);
        send_req(ACT_LOOKUP, 32'h8000_0000, 32'h0);
        send_req(ACT_LOOKUP, 32'h7FFF_FFFF, 32'h0);
        send_req(ACT_SPARE,  32'h8000_0000, 32'h1234_5678);
        // remove the entry in the last slot
        send_req(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_req(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);

        // phases that fill, drain or churn the table
        for (int p = 0; p < PHASES; p++)
        begin
            tx_gap_max = (p % 4 == 1) ? 0 : 13;
            rx_gap_max = (p % 5 == 2) ? 0 : 13;
            if (p == 6)
            begin
                tx_gap_max   = 0;
                hold_request = 1'b1;
            end
            key_pool[0] = (p % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            for (int i = 1; i < 6; i++)
                key_pool[i] = $urandom;
            bias = p % 3;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (bias == 0)
                    act = (pick < 60) ? ACT_INSERT : (pick < 80) ? ACT_REMOVE :
                          (pick < 97) ? ACT_LOOKUP : ACT_SPARE;
                else if (bias == 1)
                    act = (pick < 20) ? ACT_INSERT : (pick < 65) ? ACT_REMOVE :
                          (pick < 97) ? ACT_LOOKUP : ACT_SPARE;
                else
                    act = (pick < 35) ? ACT_INSERT : (pick < 62) ? ACT_REMOVE :
                          (pick < 97) ? ACT_LOOKUP : ACT_SPARE;
                k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 5)] : $urandom;
                send_req(act, k, $urandom);
            end
        end
        req_valid <= 1'b0;

        // let the checker count the last item, then wait for every owed result
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && owed_count == 0)
            $display("unordered_key_value_table: match");
        else
            $display("unordered_key_value_table: mismatch");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #8000000;
        $display("unordered_key_value_table: mismatch");
        $finish;
    end

endmodule
